FILE: hdl/slcan_pkg.sv
package slcan_pkg;

    localparam int unsigned LINE_LIMIT = 32;
    localparam int unsigned POS_W      = 6;

    localparam logic [7:0] CHAR_CR      = 8'h0d;
    localparam logic [7:0] CHAR_STD     = 8'h74;  // 't'
    localparam logic [7:0] CHAR_EXT     = 8'h54;  // 'T'
    localparam logic [7:0] CHAR_STD_RTR = 8'h72;  // 'r'
    localparam logic [7:0] CHAR_EXT_RTR = 8'h52;  // 'R'
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;
    localparam logic [7:0] CHAR_UA      = 8'h41;
    localparam logic [7:0] CHAR_UF      = 8'h46;
    localparam logic [7:0] CHAR_LA      = 8'h61;
    localparam logic [7:0] CHAR_LF      = 8'h66;

    localparam logic [POS_W-1:0] DLC_POS_STD = 6'd4;
    localparam logic [POS_W-1:0] DLC_POS_EXT = 6'd9;
    localparam logic [3:0]       DLC_MAX     = 4'd8;
    localparam logic [9:0]       MS_TO_US    = 10'd1000;

    typedef struct packed {
        logic        ok;
        logic [3:0]  nib;
    } hex_t;

    typedef struct packed {
        logic [28:0] frame_id;
        logic        is_extended;
        logic        is_remote;
        logic [3:0]  data_length;
        logic [63:0] payload;
        logic        has_timestamp;
        logic [25:0] timestamp_us;
        logic        malformed;
        logic [31:0] frames_total;
        logic [31:0] bytes_total;
    } frame_t;

    function automatic hex_t hex_nibble(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.nib = 4'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            h.nib = 4'(c - CHAR_ZERO);
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            h.nib = 4'(c - CHAR_UA + 8'd10);
        end else if (c >= CHAR_LA && c <= CHAR_LF) begin
            h.nib = 4'(c - CHAR_LA + 8'd10);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

FILE: hdl/slcan_parse.sv
module slcan_parse (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic [7:0]            rx_byte,
    output logic                  emit,
    output slcan_pkg::frame_t     frame
);
    import slcan_pkg::*;

    logic              collecting_reg, collecting_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              ext_reg, ext_next;
    logic              rem_reg, rem_next;
    logic [28:0]       id_reg, id_next;
    logic [3:0]        dlc_reg, dlc_next;
    logic [63:0]       data_reg, data_next;
    logic [15:0]       stamp_reg, stamp_next;
    logic              seen_reg, seen_next;
    logic              err_reg, err_next;
    logic [31:0]       frames_reg, frames_next;
    logic [31:0]       bytes_reg, bytes_next;

    hex_t              hx;
    logic              is_start;
    logic [POS_W-1:0]  dlc_pos;
    logic [POS_W-1:0]  data_start;
    logic [POS_W-1:0]  d_off;
    logic [POS_W-1:0]  s_off;
    logic [4:0]        dlen;
    logic [3:0]        nib_idx;
    logic              short_line;
    logic [31:0]       frames_inc;
    logic [31:0]       bytes_inc;

    assign hx         = hex_nibble(rx_byte);
    assign is_start   = (rx_byte == CHAR_STD) || (rx_byte == CHAR_EXT) ||
                        (rx_byte == CHAR_STD_RTR) || (rx_byte == CHAR_EXT_RTR);
    assign dlc_pos    = ext_reg ? DLC_POS_EXT : DLC_POS_STD;
    assign data_start = dlc_pos + 6'd1;
    assign dlen       = {dlc_reg, 1'b0};
    assign d_off      = pos_reg - data_start;
    assign s_off      = d_off - {1'b0, dlen};
    // first hex digit of a byte is its high nibble
    assign nib_idx    = {d_off[3:1], ~d_off[0]};
    assign short_line = {1'b0, pos_reg} < ({1'b0, data_start} + {2'b00, dlen});
    assign frames_inc = frames_reg + 32'd1;
    assign bytes_inc  = bytes_reg + {28'd0, dlc_reg};

    assign emit = collecting_reg && (rx_byte == CHAR_CR);

    always_comb begin
        frame.frame_id      = ext_reg ? id_reg : {18'd0, id_reg[10:0]};
        frame.is_extended   = ext_reg;
        frame.is_remote     = rem_reg;
        frame.data_length   = dlc_reg;
        frame.payload       = data_reg;
        frame.has_timestamp = seen_reg;
        frame.timestamp_us  = 26'({10'd0, stamp_reg} * {16'd0, MS_TO_US});
        frame.malformed     = err_reg || short_line;
        frame.frames_total  = frames_inc;
        frame.bytes_total   = bytes_inc;
    end

    always_comb begin
        collecting_next = collecting_reg;
        pos_next        = pos_reg;
        ext_next        = ext_reg;
        rem_next        = rem_reg;
        id_next         = id_reg;
        dlc_next        = dlc_reg;
        data_next       = data_reg;
        stamp_next      = stamp_reg;
        seen_next       = seen_reg;
        err_next        = err_reg;
        frames_next     = frames_reg;
        bytes_next      = bytes_reg;
        if (step_en) begin
            if (!collecting_reg) begin
                if (is_start) begin
                    collecting_next = 1'b1;
                    pos_next        = 6'd1;
                    ext_next        = (rx_byte == CHAR_EXT) || (rx_byte == CHAR_EXT_RTR);
                    rem_next        = (rx_byte == CHAR_STD_RTR) || (rx_byte == CHAR_EXT_RTR);
                    id_next         = '0;
                    dlc_next        = '0;
                    data_next       = '0;
                    stamp_next      = '0;
                    seen_next       = 1'b0;
                    err_next        = 1'b0;
                end
            end else if (rx_byte == CHAR_CR) begin
                frames_next     = frames_inc;
                bytes_next      = bytes_inc;
                collecting_next = 1'b0;
                pos_next        = '0;
            end else if (({1'b0, pos_reg} + 7'd1) >= 7'(LINE_LIMIT)) begin
                collecting_next = 1'b0;
                pos_next        = '0;
            end else begin
                pos_next = pos_reg + 6'd1;
                if (pos_reg < dlc_pos) begin
                    id_next = {id_reg[24:0], hx.nib};
                    if (!hx.ok) err_next = 1'b1;
                end else if (pos_reg == dlc_pos) begin
                    if (rx_byte >= CHAR_ZERO && rx_byte <= CHAR_NINE) begin
                        if (rx_byte == CHAR_NINE) begin
                            dlc_next = rem_reg ? 4'd0 : DLC_MAX;
                            err_next = 1'b1;
                        end else begin
                            dlc_next = rem_reg ? 4'd0 : 4'(rx_byte - CHAR_ZERO);
                        end
                    end else begin
                        dlc_next = 4'd0;
                        err_next = 1'b1;
                    end
                end else if ({1'b0, d_off} < {2'b00, dlen}) begin
                    data_next = data_reg | ({60'd0, hx.nib} << {nib_idx, 2'b00});
                    if (!hx.ok) err_next = 1'b1;
                end else begin
                    seen_next = 1'b1;
                    if (s_off < 6'd4) begin
                        stamp_next = {stamp_reg[11:0], hx.nib};
                        if (!hx.ok) err_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            pos_reg        <= '0;
            ext_reg        <= 1'b0;
            rem_reg        <= 1'b0;
            id_reg         <= '0;
            dlc_reg        <= '0;
            data_reg       <= '0;
            stamp_reg      <= '0;
            seen_reg       <= 1'b0;
            err_reg        <= 1'b0;
            frames_reg     <= '0;
            bytes_reg      <= '0;
        end else begin
            collecting_reg <= collecting_next;
            pos_reg        <= pos_next;
            ext_reg        <= ext_next;
            rem_reg        <= rem_next;
            id_reg         <= id_next;
            dlc_reg        <= dlc_next;
            data_reg       <= data_next;
            stamp_reg      <= stamp_next;
            seen_reg       <= seen_next;
            err_reg        <= err_next;
            frames_reg     <= frames_next;
            bytes_reg      <= bytes_next;
        end
    end

endmodule

FILE: hdl/slcan_ascii_frame_parser_core.sv
// Parses ASCII serial CAN lines (t/T/r/R, ID, DLC, data, optional ms timestamp,
// CR) one received byte per transaction and returns one decoded frame per CR
// that ends a line. Each byte is registered on entry, decoded against the line
// state and any frame lands in the output register, so a byte is taken every
// cycle; a byte that ends a line waits only while the output register still
// holds an untaken frame. A line longer than LINE_LIMIT characters, CR
// included, is dropped without a frame.
module slcan_ascii_frame_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [28:0] m_frame_id,
    output logic        m_is_extended,
    output logic        m_is_remote,
    output logic [3:0]  m_data_length,
    output logic [63:0] m_payload,
    output logic        m_has_timestamp,
    output logic [25:0] m_timestamp_us,
    output logic        m_malformed,
    output logic [31:0] m_frames_total,
    output logic [31:0] m_bytes_total
);
    import slcan_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg, out_valid_next;
    frame_t     out_reg;
    frame_t     frame;
    logic       emit;
    logic       step_fire;

    assign step_fire = in_valid_reg && (!emit || !out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_fire;

    slcan_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_fire),
        .rx_byte (in_byte_reg),
        .emit    (emit),
        .frame   (frame)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step_fire && emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (step_fire && emit) begin
            out_reg <= frame;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_frame_id      = out_reg.frame_id;
    assign m_is_extended   = out_reg.is_extended;
    assign m_is_remote     = out_reg.is_remote;
    assign m_data_length   = out_reg.data_length;
    assign m_payload       = out_reg.payload;
    assign m_has_timestamp = out_reg.has_timestamp;
    assign m_timestamp_us  = out_reg.timestamp_us;
    assign m_malformed     = out_reg.malformed;
    assign m_frames_total  = out_reg.frames_total;
    assign m_bytes_total   = out_reg.bytes_total;

    // a new frame only comes from a CR sitting in the input register
    a_frame_from_cr: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && emit) |-> (in_byte_reg == CHAR_CR))
        else $error("frame emitted without CR");

    a_dlc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data_length <= DLC_MAX))
        else $error("data length above 8");

    a_remote_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_is_remote) |-> (m_data_length == 4'd0 && m_payload == 64'd0))
        else $error("remote frame carries data");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(step_fire && emit))
        else $error("pending frame overwritten");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import slcan_pkg::*;

    // Line decoder predictor plus the queue of frames it expects from the DUT.
    class slcan_line_scoreboard;
        bit          collecting;
        int unsigned char_pos;
        bit          kind_ext;
        bit          kind_rem;
        logic [28:0] id_acc;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic [15:0] stamp;
        bit          stamp_seen;
        bit          bad;
        logic [31:0] frame_count;
        logic [31:0] byte_count;
        frame_t      expected_frames[$];
        int unsigned mismatches;
        int unsigned frames_checked;

        function new();
            collecting     = 1'b0;
            char_pos       = 0;
            kind_ext       = 1'b0;
            kind_rem       = 1'b0;
            id_acc         = '0;
            dlc            = '0;
            data           = '0;
            stamp          = '0;
            stamp_seen     = 1'b0;
            bad            = 1'b0;
            frame_count    = '0;
            byte_count     = '0;
            mismatches     = 0;
            frames_checked = 0;
        endfunction

        function int unsigned pending();
            return expected_frames.size();
        endfunction

        function logic [3:0] hex_value(logic [7:0] c, output bit ok);
            ok = 1'b1;
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                return 4'(c - CHAR_ZERO);
            end
            if (c >= CHAR_UA && c <= CHAR_UF) begin
                return 4'(c - CHAR_UA + 8'd10);
            end
            if (c >= CHAR_LA && c <= CHAR_LF) begin
                return 4'(c - CHAR_LA + 8'd10);
            end
            ok = 1'b0;
            return 4'd0;
        endfunction

        function void note_rx_byte(logic [7:0] c);
            frame_t      f;
            bit          ok;
            int unsigned dlc_pos, data_start, d, dlen, shift;
            logic [3:0]  nib;
            if (!collecting) begin
                if (c == CHAR_STD || c == CHAR_EXT || c == CHAR_STD_RTR || c == CHAR_EXT_RTR) begin
                    collecting = 1'b1;
                    char_pos   = 1;
                    kind_ext   = (c == CHAR_EXT || c == CHAR_EXT_RTR);
                    kind_rem   = (c == CHAR_STD_RTR || c == CHAR_EXT_RTR);
                    id_acc     = '0;
                    dlc        = '0;
                    data       = '0;
                    stamp      = '0;
                    stamp_seen = 1'b0;
                    bad        = 1'b0;
                end
                return;
            end
            dlc_pos    = kind_ext ? 9 : 4;
            data_start = dlc_pos + 1;
            if (c == CHAR_CR) begin
                frame_count     = frame_count + 32'd1;
                byte_count      = byte_count + 32'(dlc);
                f.frame_id      = kind_ext ? id_acc : {18'd0, id_acc[10:0]};
                f.is_extended   = kind_ext;
                f.is_remote     = kind_rem;
                f.data_length   = dlc;
                f.payload       = data;
                f.has_timestamp = stamp_seen;
                f.timestamp_us  = 26'(32'(stamp) * 32'd1000);
                // a CR before all expected digits arrived marks the frame bad
                f.malformed     = bad || (char_pos < data_start + 2 * 32'(dlc));
                f.frames_total  = frame_count;
                f.bytes_total   = byte_count;
                expected_frames.push_back(f);
                collecting = 1'b0;
                char_pos   = 0;
                return;
            end
            if (char_pos + 1 >= LINE_LIMIT) begin
                collecting = 1'b0;
                char_pos   = 0;
                return;
            end
            if (char_pos < dlc_pos) begin
                nib    = hex_value(c, ok);
                bad    = bad | !ok;
                id_acc = {id_acc[24:0], nib};
            end else if (char_pos == dlc_pos) begin
                nib = 4'd0;
                if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                    nib = 4'(c - CHAR_ZERO);
                    if (nib > DLC_MAX) begin
                        nib = DLC_MAX;
                        bad = 1'b1;
                    end
                end else begin
                    bad = 1'b1;
                end
                dlc = kind_rem ? 4'd0 : nib;
            end else begin
                d    = char_pos - data_start;
                dlen = 2 * 32'(dlc);
                if (d < dlen) begin
                    // high nibble of each byte comes first
                    shift = 8 * (d / 2) + ((d % 2 == 0) ? 4 : 0);
                    nib   = hex_value(c, ok);
                    bad   = bad | !ok;
                    data  = data | (64'(nib) << shift);
                end else begin
                    stamp_seen = 1'b1;
                    if (d - dlen < 4) begin
                        nib   = hex_value(c, ok);
                        bad   = bad | !ok;
                        stamp = {stamp[11:0], nib};
                    end
                end
            end
            char_pos = char_pos + 1;
        endfunction

        function void field_check(string name, logic [63:0] want, logic [63:0] got_v);
            if (want !== got_v) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("frame %0d %s: expected 0x%0h got 0x%0h",
                             frames_checked, name, want, got_v);
                end
            end
        endfunction

        function void check_frame(frame_t got);
            frame_t want;
            frames_checked++;
            if (expected_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("frame %0d: unexpected frame id 0x%0h", frames_checked,
                             got.frame_id);
                end
                return;
            end
            want = expected_frames.pop_front();
            field_check("frame_id",      64'(want.frame_id),      64'(got.frame_id));
            field_check("is_extended",   64'(want.is_extended),   64'(got.is_extended));
            field_check("is_remote",     64'(want.is_remote),     64'(got.is_remote));
            field_check("data_length",   64'(want.data_length),   64'(got.data_length));
            field_check("payload",       want.payload,            got.payload);
            field_check("has_timestamp", 64'(want.has_timestamp), 64'(got.has_timestamp));
            field_check("timestamp_us",  64'(want.timestamp_us),  64'(got.timestamp_us));
            field_check("malformed",     64'(want.malformed),     64'(got.malformed));
            field_check("frames_total",  64'(want.frames_total),  64'(got.frames_total));
            field_check("bytes_total",   64'(want.bytes_total),   64'(got.bytes_total));
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'd0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [28:0] m_frame_id;
    logic        m_is_extended;
    logic        m_is_remote;
    logic [3:0]  m_data_length;
    logic [63:0] m_payload;
    logic        m_has_timestamp;
    logic [25:0] m_timestamp_us;
    logic        m_malformed;
    logic [31:0] m_frames_total;
    logic [31:0] m_bytes_total;

    slcan_line_scoreboard sb;
    bit                   quiet_phase  = 1'b0;
    bit                   hold_request = 1'b0;
    logic [7:0]           line_q[$];
    int unsigned          noise_cnt;

    slcan_ascii_frame_parser_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_id      (m_frame_id),
        .m_is_extended   (m_is_extended),
        .m_is_remote     (m_is_remote),
        .m_data_length   (m_data_length),
        .m_payload       (m_payload),
        .m_has_timestamp (m_has_timestamp),
        .m_timestamp_us  (m_timestamp_us),
        .m_malformed     (m_malformed),
        .m_frames_total  (m_frames_total),
        .m_bytes_total   (m_bytes_total)
    );

    always #5 aclk = ~aclk;

    initial sb = new();

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int unsigned gap_len();
        int unsigned r;
        if (quiet_phase) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return CHAR_ZERO + 8'(nib);
        end
        return ($urandom_range(0, 1) ? CHAR_UA : CHAR_LA) + 8'(nib) - 8'd10;
    endfunction

    // Builds one line into line_q: mostly well formed, a quarter of them damaged.
    function automatic void build_line();
        bit          ext, rem;
        int unsigned nid, dlc_n, nts, p, mode, n;
        logic [7:0]  b;
        line_q.delete();
        noise_cnt = 0;
        ext = $urandom_range(0, 1);
        rem = $urandom_range(0, 1);
        line_q.push_back(ext ? (rem ? CHAR_EXT_RTR : CHAR_EXT) : (rem ? CHAR_STD_RTR : CHAR_STD));
        nid = ext ? 8 : 3;
        repeat (nid) line_q.push_back(hex_char(4'($urandom_range(0, 15))));
        dlc_n = $urandom_range(0, 8);
        line_q.push_back(CHAR_ZERO + 8'(dlc_n));
        if (!rem) begin
            repeat (2 * dlc_n) line_q.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        if ($urandom_range(0, 2) != 0) begin
            nts = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 4;
            repeat (nts) line_q.push_back(hex_char(4'($urandom_range(0, 15))));
        end
        mode = $urandom_range(0, 99);
        if (mode >= 75) begin
            p = $urandom_range(1, line_q.size() - 1);
            case (mode % 5)
                0: begin
                    line_q[p] = 8'($urandom_range(0, 255));
                end
                1: begin
                    while (line_q.size() > p) void'(line_q.pop_back());
                end
                2: begin
                    line_q[nid + 1] = $urandom_range(0, 1) ? CHAR_NINE
                                                          : 8'($urandom_range(0, 255));
                end
                3: begin
                    // runs right up to, or one past, the line length limit
                    n = LINE_LIMIT - $urandom_range(0, 1);
                    while (line_q.size() < n) line_q.push_back(hex_char(4'($urandom_range(0, 15))));
                end
                default: begin
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        b = 8'($urandom_range(0, 255));
                        if (b == CHAR_STD || b == CHAR_EXT || b == CHAR_STD_RTR ||
                            b == CHAR_EXT_RTR) begin
                            b = 8'h00;
                        end
                        line_q.push_front(b);
                    end
                    noise_cnt = n;
                end
            endcase
        end
        line_q.push_back(CHAR_CR);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = gap_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    task automatic send_line(input string s);
        send_str(s);
        send_byte(CHAR_CR);
    endtask

    task automatic send_built_line();
        foreach (line_q[i]) begin
            send_byte(line_q[i]);
        end
    endtask

    always @(posedge aclk) begin
        frame_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_rx_byte(s_rx_byte);
            end
            if (m_valid && m_ready) begin
                got.frame_id      = m_frame_id;
                got.is_extended   = m_is_extended;
                got.is_remote     = m_is_remote;
                got.data_length   = m_data_length;
                got.payload       = m_payload;
                got.has_timestamp = m_has_timestamp;
                got.timestamp_us  = m_timestamp_us;
                got.malformed     = m_malformed;
                got.frames_total  = m_frames_total;
                got.bytes_total   = m_bytes_total;
                sb.check_frame(got);
            end
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                stall_left   = 400;
                hold_request = 1'b0;
            end
            if (stall_left == 0) begin
                stall_left = gap_len();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        int unsigned sent, line_no;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // idle noise, CR included, must be ignored
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_CR);
        send_str("zq5");
        send_line("t0000");
        send_line({"t7FF8", "FFFFFFFFFFFFFFFF", "FFFF"});
        send_line({"T1FFFFFFF8", "0123456789abcdef"});
        send_line("TFFFFFFFF0");
        send_line("r1234");
        send_line("R000000005ABCD");
        send_line({"t1239", "0011223344556677"});
        send_line("t123x");
        send_line("t1G3100");
        send_line("t12320zz");
        send_line("t1230FFFFAB");
        send_line("t1230ab!z");
        send_line("t12");
        send_line("T");
        send_line("t1t30");
        send_line("r7FF9");
        // 31 characters plus CR still fits; one more drops the line
        send_line({"T1FFFFFFF8", "0123456789ABCDEF", "12345"});
        send_line({"T1FFFFFFF8", "0123456789ABCDEF", "123456"});
        send_line("t5A52C3D");

        sent    = 0;
        line_no = 0;
        while (sent < 1800) begin
            if (line_no % 10 == 0) begin
                quiet_phase = ($urandom_range(0, 3) == 0);
            end
            if (line_no == 30) begin
                hold_request = 1'b1;
            end
            if (line_no == 70) begin
                s_valid <= 1'b0;
                while (sb.pending() != 0) @(negedge aclk);
            end
            build_line();
            send_built_line();
            sent    = sent + line_q.size() - noise_cnt;
            line_no = line_no + 1;
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
